/* hw/rtl/hvot_pkg.sv */
package hvot_pkg;

  localparam int COORD_W    = 32;
  localparam int YAW_W      = 16;
  localparam int ANGLE_BITS = 16;
  localparam int TRIG_W     = 18;
  localparam int TRIG_STG   = 5;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // shape codes
  localparam logic [1:0] SHAPE_BOX    = 2'd0;
  localparam logic [1:0] SHAPE_TURNED = 2'd1;
  localparam logic [1:0] SHAPE_SPHERE = 2'd2;
  localparam logic [1:0] SHAPE_ALT    = 2'd3;

  // register indexes
  localparam logic [2:0] REG_A_SHAPE    = 3'd0;
  localparam logic [2:0] REG_A_CENTER_X = 3'd1;
  localparam logic [2:0] REG_A_CENTER_Y = 3'd2;
  localparam logic [2:0] REG_A_CENTER_Z = 3'd3;
  localparam logic [2:0] REG_A_HALF_X   = 3'd4;
  localparam logic [2:0] REG_A_HALF_Y   = 3'd5;
  localparam logic [2:0] REG_A_HALF_Z   = 3'd6;
  localparam logic [2:0] REG_A_YAW      = 3'd7;

  // sine polynomial coefficients, Q15
  localparam logic [15:0] SIN_A = 16'd51472;
  localparam logic [15:0] SIN_B = 16'd21024;
  localparam logic [15:0] SIN_C = 16'd2320;

  localparam logic [31:0] QUARTER   = 32'h4000_0000;
  localparam logic [30:0] QUARTER_X = 31'h4000_0000;

  typedef logic [TRIG_STG-1:0] trig_en_t;

endpackage

/* hw/rtl/hvot_if.sv */
interface hvot_cand_if;
  import hvot_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                b_shape;
  logic signed [COORD_W-1:0] b_center_x;
  logic signed [COORD_W-1:0] b_center_y;
  logic signed [COORD_W-1:0] b_center_z;
  logic signed [COORD_W-1:0] b_half_x;
  logic signed [COORD_W-1:0] b_half_y;
  logic signed [COORD_W-1:0] b_half_z;
  logic [YAW_W-1:0]          b_yaw;

  modport source (
    output valid, b_shape, b_center_x, b_center_y, b_center_z,
    output b_half_x, b_half_y, b_half_z, b_yaw,
    input  ready
  );
  modport sink (
    input  valid, b_shape, b_center_x, b_center_y, b_center_z,
    input  b_half_x, b_half_y, b_half_z, b_yaw,
    output ready
  );
endinterface

interface hvot_result_if;
  logic valid;
  logic ready;
  logic overlaps;

  modport source (output valid, overlaps, input ready);
  modport sink (input valid, overlaps, output ready);
endinterface

/* hw/rtl/hvot_sincos.sv */
module hvot_sincos (
  input  logic                               clk,
  input  hvot_pkg::trig_en_t                 en,
  input  logic [hvot_pkg::YAW_W-1:0]         yaw,
  input  logic                               quarter,
  output logic signed [hvot_pkg::TRIG_W-1:0] val
);
  import hvot_pkg::*;

  logic [31:0] phase;
  logic [30:0] x;
  logic [15:0] x15_1, x15_2, x15_3, x15_4;
  logic        neg1, neg2, neg3, neg4;
  logic [15:0] x2_2, x2_3;
  logic [14:0] t3;
  logic [15:0] t4;
  logic [31:0] p2, p3, p4, p5;

  // quarter-turn reduction; cosine adds a quarter turn
  always_comb begin
    phase = {yaw[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}} + (quarter ? QUARTER : 32'd0);
    x = phase[30] ? (QUARTER_X - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
  end

  always_comb begin
    p2 = 32'(x15_1) * 32'(x15_1);
    p3 = 32'(SIN_C) * 32'(x2_2);
    p4 = 32'(t3) * 32'(x2_3);
    p5 = 32'(t4) * 32'(x15_4);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x15_1 <= x[30:15];
      neg1  <= phase[31];
    end
    if (en[1]) begin
      x2_2  <= p2[30:15];
      x15_2 <= x15_1;
      neg2  <= neg1;
    end
    if (en[2]) begin
      t3    <= 15'(SIN_B - p3[30:15]);
      x2_3  <= x2_2;
      x15_3 <= x15_2;
      neg3  <= neg2;
    end
    if (en[3]) begin
      t4    <= SIN_A - p4[30:15];
      x15_4 <= x15_3;
      neg4  <= neg3;
    end
    if (en[4]) begin
      val <= neg4 ? -$signed({1'b0, p5[31:15]}) : $signed({1'b0, p5[31:15]});
    end
  end

endmodule

/* hw/rtl/hit_volume_overlap_test.sv */
// channel  | dir | fields
// cand     | in  | b_shape, b_center_x/y/z, b_half_x/y/z, b_yaw
// result   | out | overlaps
// apb      | in  | a_shape .. a_yaw at byte address 4*index
//
// one item per cycle while the result side is ready; the depth is set by
// the four dependent multiplies of the sine polynomial plus the projection,
// square and compare stages after it
// reset clears the stage valid bits and the volume A registers
// each stage advances when it is empty or the next one advances, so bubbles
// close up and items are taken while a result waits at the output
module hit_volume_overlap_test (
  input  logic                                clk,
  input  logic                                rst,
  hvot_cand_if.sink                           cand,
  hvot_result_if.source                       result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hvot_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [hvot_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [hvot_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import hvot_pkg::*;

  localparam int NSTG = 11;

  typedef struct packed {
    logic               b_sph;
    logic signed [32:0] dx;
    logic signed [32:0] dz;
    logic [30:0]        bhx;
    logic [30:0]        bhz;
    logic               y_ok;
    logic [32:0]        ey;
    logic [31:0]        r;
  } carry_t;

  function automatic logic [1:0] norm_shape(input logic [1:0] s);
    return (s == SHAPE_ALT) ? SHAPE_BOX : s;
  endfunction

  function automatic logic [30:0] clamp_half(input logic signed [31:0] h);
    return h[31] ? 31'd0 : h[30:0];
  endfunction

  // volume A registers
  logic [1:0]                a_shape;
  logic signed [COORD_W-1:0] a_center_x, a_center_y, a_center_z;
  logic signed [COORD_W-1:0] a_half_x, a_half_y, a_half_z;
  logic [YAW_W-1:0]          a_yaw;
  logic [2:0]                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_shape    <= '0;
      a_center_x <= '0;
      a_center_y <= '0;
      a_center_z <= '0;
      a_half_x   <= '0;
      a_half_y   <= '0;
      a_half_z   <= '0;
      a_yaw      <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (cfg_idx)
        REG_A_SHAPE:    a_shape    <= pwdata[1:0];
        REG_A_CENTER_X: a_center_x <= pwdata;
        REG_A_CENTER_Y: a_center_y <= pwdata;
        REG_A_CENTER_Z: a_center_z <= pwdata;
        REG_A_HALF_X:   a_half_x   <= pwdata;
        REG_A_HALF_Y:   a_half_y   <= pwdata;
        REG_A_HALF_Z:   a_half_z   <= pwdata;
        REG_A_YAW:      a_yaw      <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_A_SHAPE:    prdata = 32'(a_shape);
      REG_A_CENTER_X: prdata = a_center_x;
      REG_A_CENTER_Y: prdata = a_center_y;
      REG_A_CENTER_Z: prdata = a_center_z;
      REG_A_HALF_X:   prdata = a_half_x;
      REG_A_HALF_Y:   prdata = a_half_y;
      REG_A_HALF_Z:   prdata = a_half_z;
      REG_A_YAW:      prdata = 32'(a_yaw);
    endcase
  end

  // volume A derived values, user keeps stable while items are in flight
  logic [1:0]  a_shape_n, b_shape_n;
  logic        a_sph, b_sph_in;
  logic [30:0] a_hx, a_hy, a_hz;
  logic [YAW_W-1:0] a_yaw_eff, b_yaw_eff;

  always_comb begin
    a_shape_n = norm_shape(a_shape);
    b_shape_n = norm_shape(cand.b_shape);
    a_sph     = (a_shape_n == SHAPE_SPHERE);
    b_sph_in  = (b_shape_n == SHAPE_SPHERE);
    a_hx      = clamp_half(a_half_x);
    a_hy      = clamp_half(a_half_y);
    a_hz      = clamp_half(a_half_z);
    a_yaw_eff = (a_shape_n == SHAPE_TURNED) ? a_yaw : '0;
    b_yaw_eff = (b_shape_n == SHAPE_TURNED) ? cand.b_yaw : '0;
  end

  // stage control
  logic [NSTG:1] v;
  logic [NSTG:1] en;

  always_comb begin
    en[NSTG] = !v[NSTG] || result.ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign cand.ready   = en[1];
  assign result.valid = v[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= cand.valid;
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // sine and cosine of both volumes, stages 1 to 5
  logic signed [TRIG_W-1:0] sin_a, cos_a, sin_b, cos_b;

  hvot_sincos u_sin_a (.clk(clk), .en(en[5:1]), .yaw(a_yaw_eff), .quarter(1'b0), .val(sin_a));
  hvot_sincos u_cos_a (.clk(clk), .en(en[5:1]), .yaw(a_yaw_eff), .quarter(1'b1), .val(cos_a));
  hvot_sincos u_sin_b (.clk(clk), .en(en[5:1]), .yaw(b_yaw_eff), .quarter(1'b0), .val(sin_b));
  hvot_sincos u_cos_b (.clk(clk), .en(en[5:1]), .yaw(b_yaw_eff), .quarter(1'b1), .val(cos_b));

  // stage 1: center differences b - a, clamped extents
  logic               s1_b_sph;
  logic signed [32:0] s1_dx, s1_dy, s1_dz;
  logic [30:0]        s1_bhx, s1_bhy, s1_bhz;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_b_sph <= b_sph_in;
      s1_dx    <= 33'(cand.b_center_x) - 33'(a_center_x);
      s1_dy    <= 33'(cand.b_center_y) - 33'(a_center_y);
      s1_dz    <= 33'(cand.b_center_z) - 33'(a_center_z);
      s1_bhx   <= clamp_half(cand.b_half_x);
      s1_bhy   <= clamp_half(cand.b_half_y);
      s1_bhz   <= clamp_half(cand.b_half_z);
    end
  end

  // stage 2: vertical axis and sphere radius
  carry_t cr [2:8];
  carry_t cr2_next;
  logic [32:0] dym;
  logic [31:0] hy_sum;
  logic [30:0] box_hy;
  logic        both2;

  always_comb begin
    dym    = s1_dy[32] ? 33'(-s1_dy) : 33'(s1_dy);
    hy_sum = 32'(a_hy) + 32'(s1_bhy);
    both2  = a_sph && s1_b_sph;
    box_hy = both2 ? 31'd0 : (a_sph ? s1_bhy : a_hy);
    cr2_next.b_sph = s1_b_sph;
    cr2_next.dx    = s1_dx;
    cr2_next.dz    = s1_dz;
    cr2_next.bhx   = s1_bhx;
    cr2_next.bhz   = s1_bhz;
    cr2_next.y_ok  = (dym <= 33'(hy_sum));
    cr2_next.ey    = (dym > 33'(box_hy)) ? (dym - 33'(box_hy)) : 33'd0;
    cr2_next.r     = both2 ? (32'(a_hx) + 32'(s1_bhx)) : (a_sph ? 32'(a_hx) : 32'(s1_bhx));
  end

  always_ff @(posedge clk) begin
    if (en[2]) cr[2] <= cr2_next;
    for (int k = 3; k <= 8; k++) begin
      if (en[k]) cr[k] <= cr[k-1];
    end
  end

  // stage 6: products for the four axes and the axis dot products
  logic signed [50:0] s6_pxa_c, s6_pza_s, s6_pxa_s, s6_pza_c;
  logic signed [50:0] s6_pxb_c, s6_pzb_s, s6_pxb_s, s6_pzb_c;
  logic signed [35:0] s6_aa_c, s6_aa_s, s6_bb_c, s6_bb_s;
  logic signed [35:0] s6_ab_cc, s6_ab_ss, s6_ab_cs, s6_ab_sc;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_pxa_c <= 51'($signed(cr[5].dx)) * 51'(cos_a);
      s6_pza_s <= 51'($signed(cr[5].dz)) * 51'(sin_a);
      s6_pxa_s <= 51'($signed(cr[5].dx)) * 51'(sin_a);
      s6_pza_c <= 51'($signed(cr[5].dz)) * 51'(cos_a);
      s6_pxb_c <= 51'($signed(cr[5].dx)) * 51'(cos_b);
      s6_pzb_s <= 51'($signed(cr[5].dz)) * 51'(sin_b);
      s6_pxb_s <= 51'($signed(cr[5].dx)) * 51'(sin_b);
      s6_pzb_c <= 51'($signed(cr[5].dz)) * 51'(cos_b);
      s6_aa_c  <= 36'(cos_a) * 36'(cos_a);
      s6_aa_s  <= 36'(sin_a) * 36'(sin_a);
      s6_bb_c  <= 36'(cos_b) * 36'(cos_b);
      s6_bb_s  <= 36'(sin_b) * 36'(sin_b);
      s6_ab_cc <= 36'(cos_a) * 36'(cos_b);
      s6_ab_ss <= 36'(sin_a) * 36'(sin_b);
      s6_ab_cs <= 36'(cos_a) * 36'(sin_b);
      s6_ab_sc <= 36'(sin_a) * 36'(cos_b);
    end
  end

  // stage 7: projected center distances and truncated axis dot products
  logic signed [51:0] d_ax, d_az, d_bx, d_bz;
  logic signed [36:0] n_a, n_b, c_1, c_2;
  logic [36:0]        c1m, c2m;
  logic [51:0]        s7_max, s7_maz, s7_mbx, s7_mbz;
  logic [21:0]        s7_qa, s7_qb, s7_q1, s7_q2;

  always_comb begin
    d_ax = 52'(s6_pxa_c) - 52'(s6_pza_s);
    d_az = 52'(s6_pxa_s) + 52'(s6_pza_c);
    d_bx = 52'(s6_pxb_c) - 52'(s6_pzb_s);
    d_bz = 52'(s6_pxb_s) + 52'(s6_pzb_c);
    n_a  = 37'(s6_aa_c) + 37'(s6_aa_s);
    n_b  = 37'(s6_bb_c) + 37'(s6_bb_s);
    // a-x with b-x equals a-z with b-z; a-x with b-z is minus a-z with b-x
    c_1  = 37'(s6_ab_cc) + 37'(s6_ab_ss);
    c_2  = 37'(s6_ab_cs) - 37'(s6_ab_sc);
    c1m  = c_1[36] ? 37'(-c_1) : 37'(c_1);
    c2m  = c_2[36] ? 37'(-c_2) : 37'(c_2);
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_max <= d_ax[51] ? 52'(-d_ax) : 52'(d_ax);
      s7_maz <= d_az[51] ? 52'(-d_az) : 52'(d_az);
      s7_mbx <= d_bx[51] ? 52'(-d_bx) : 52'(d_bx);
      s7_mbz <= d_bz[51] ? 52'(-d_bz) : 52'(d_bz);
      s7_qa  <= n_a[36:15];
      s7_qb  <= n_b[36:15];
      s7_q1  <= c1m[36:15];
      s7_q2  <= c2m[36:15];
    end
  end

  // stage 8: extents projected on each axis, sphere excess in the box frame
  logic [52:0] s8_qa_ahx, s8_qa_ahz, s8_qb_bhx, s8_qb_bhz;
  logic [52:0] s8_q1_bhx, s8_q2_bhz, s8_q2_bhx, s8_q1_bhz;
  logic [52:0] s8_q1_ahx, s8_q2_ahz, s8_q2_ahx, s8_q1_ahz;
  logic [51:0] s8_max, s8_maz, s8_mbx, s8_mbz;
  logic [36:0] s8_ex, s8_ez;
  logic [36:0] lxm, lzm;
  logic [30:0] box_hx, box_hz;
  logic        both7;

  always_comb begin
    both7  = a_sph && cr[7].b_sph;
    // the box is b when a is a sphere; two spheres use b with no turn
    lxm    = a_sph ? s7_mbx[51:15] : s7_max[51:15];
    lzm    = a_sph ? s7_mbz[51:15] : s7_maz[51:15];
    box_hx = both7 ? 31'd0 : (a_sph ? cr[7].bhx : a_hx);
    box_hz = both7 ? 31'd0 : (a_sph ? cr[7].bhz : a_hz);
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_qa_ahx <= 53'(s7_qa) * 53'(a_hx);
      s8_qa_ahz <= 53'(s7_qa) * 53'(a_hz);
      s8_qb_bhx <= 53'(s7_qb) * 53'(cr[7].bhx);
      s8_qb_bhz <= 53'(s7_qb) * 53'(cr[7].bhz);
      s8_q1_bhx <= 53'(s7_q1) * 53'(cr[7].bhx);
      s8_q2_bhz <= 53'(s7_q2) * 53'(cr[7].bhz);
      s8_q2_bhx <= 53'(s7_q2) * 53'(cr[7].bhx);
      s8_q1_bhz <= 53'(s7_q1) * 53'(cr[7].bhz);
      s8_q1_ahx <= 53'(s7_q1) * 53'(a_hx);
      s8_q2_ahz <= 53'(s7_q2) * 53'(a_hz);
      s8_q2_ahx <= 53'(s7_q2) * 53'(a_hx);
      s8_q1_ahz <= 53'(s7_q1) * 53'(a_hz);
      s8_max    <= s7_max;
      s8_maz    <= s7_maz;
      s8_mbx    <= s7_mbx;
      s8_mbz    <= s7_mbz;
      s8_ex     <= (lxm > 37'(box_hx)) ? (lxm - 37'(box_hx)) : 37'd0;
      s8_ez     <= (lzm > 37'(box_hz)) ? (lzm - 37'(box_hz)) : 37'd0;
    end
  end

  // stage 9: separating axis compares, sphere far check
  logic [54:0] t_ax, t_az, t_bx, t_bz;
  logic        s9_box_hit, s9_far, s9_sph;
  logic [31:0] s9_ex, s9_ey, s9_ez, s9_r;

  always_comb begin
    t_ax = 55'(s8_qa_ahx) + 55'(s8_q1_bhx) + 55'(s8_q2_bhz);
    t_az = 55'(s8_qa_ahz) + 55'(s8_q2_bhx) + 55'(s8_q1_bhz);
    t_bx = 55'(s8_q1_ahx) + 55'(s8_q2_ahz) + 55'(s8_qb_bhx);
    t_bz = 55'(s8_q2_ahx) + 55'(s8_q1_ahz) + 55'(s8_qb_bhz);
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_box_hit <= cr[8].y_ok
                    && (55'(s8_max) <= t_ax) && (55'(s8_maz) <= t_az)
                    && (55'(s8_mbx) <= t_bx) && (55'(s8_mbz) <= t_bz);
      s9_far     <= (s8_ex > 37'(cr[8].r)) || (cr[8].ey > 33'(cr[8].r))
                    || (s8_ez > 37'(cr[8].r));
      s9_sph     <= a_sph || cr[8].b_sph;
      s9_ex      <= s8_ex[31:0];
      s9_ey      <= cr[8].ey[31:0];
      s9_ez      <= s8_ez[31:0];
      s9_r       <= cr[8].r;
    end
  end

  // stage 10: squares
  logic [63:0] s10_sqx, s10_sqy, s10_sqz, s10_sqr;
  logic        s10_box_hit, s10_far, s10_sph;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s10_sqx     <= 64'(s9_ex) * 64'(s9_ex);
      s10_sqy     <= 64'(s9_ey) * 64'(s9_ey);
      s10_sqz     <= 64'(s9_ez) * 64'(s9_ez);
      s10_sqr     <= 64'(s9_r) * 64'(s9_r);
      s10_box_hit <= s9_box_hit;
      s10_far     <= s9_far;
      s10_sph     <= s9_sph;
    end
  end

  // stage 11: output register
  logic [65:0] sq_sum;
  logic        s11_hit;

  always_comb begin
    sq_sum = 66'(s10_sqx) + 66'(s10_sqy) + 66'(s10_sqz);
  end

  always_ff @(posedge clk) begin
    if (en[11]) begin
      s11_hit <= s10_sph ? (!s10_far && (sq_sum <= 66'(s10_sqr))) : s10_box_hit;
    end
  end

  assign result.overlaps = s11_hit;

endmodule
